>>> rtl/core/gauss_jordan_reducer_macros.svh
// ----------------------------------------------------------------------------
// Gauss-Jordan reducer assertion macros
// Shared concurrent assertion forms, clocked on clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef GAUSS_JORDAN_REDUCER_MACROS_SVH
`define GAUSS_JORDAN_REDUCER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GJR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The expression must never be true.
`define GJR_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

>>> rtl/core/gjr_pkg.sv
// ----------------------------------------------------------------------------
// gjr_pkg
// Types, constants and helper functions of the Gauss-Jordan reducer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gjr_pkg;

	localparam int MAX_ROWS    = 8;
	localparam int MAX_COLS    = 16;
	localparam int ROW_PITCH   = MAX_COLS + 1;
	localparam int STORE_DEPTH = MAX_ROWS * ROW_PITCH;
	localparam int AW          = $clog2(STORE_DEPTH);
	localparam int RW          = $clog2(MAX_ROWS + 1);
	localparam int CW          = $clog2(MAX_COLS + 1);
	localparam int DW          = 32;
	localparam int FRAC        = 16;
	localparam int MAGW        = DW + FRAC;
	localparam int CFG_W       = 5;

	typedef enum logic [1:0] {
		REQ_WRITE = 2'd0,
		REQ_RUN   = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_SINGULAR = 2'd1,
		STAT_SAT      = 2'd2
	} status_t;

	typedef enum logic {
		CFG_ROWS = 1'b0,
		CFG_COLS = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [2:0]        row_index;
		logic [4:0]        col_index;
		logic signed [31:0] entry_value;
	} gjr_in_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         run_status;
	} gjr_out_t;

	typedef struct packed {
		logic          sat;
		logic [DW-1:0] value;
	} sat_val_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_RD_WAIT,
		ST_PIV_RD,
		ST_PIV_CHK,
		ST_SWP_RDA,
		ST_SWP_RDB,
		ST_SWP_WRA,
		ST_SWP_WRB,
		ST_NRM_RD0,
		ST_NRM_PIV,
		ST_NRM_RD,
		ST_NRM_DIV,
		ST_NRM_WAIT,
		ST_ELM_RDF,
		ST_ELM_FAC,
		ST_ELM_RDS,
		ST_ELM_RDD,
		ST_ELM_WR
	} state_t;

	function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		cell_addr = AW'(r) * AW'(ROW_PITCH) + AW'(c);
	endfunction

	function automatic logic [DW-1:0] mag_of(input logic [DW-1:0] v);
		mag_of = v[DW-1] ? (~v + DW'(1)) : v;
	endfunction

	// Turns a sign and a magnitude into a saturated Q16.16 value.
	function automatic sat_val_t from_mag(input logic neg, input logic [MAGW-1:0] mag);
		sat_val_t res;
		if (neg) begin
			if (mag > {{(MAGW-DW){1'b0}}, 1'b1, {(DW-1){1'b0}}}) begin
				res.sat   = 1'b1;
				res.value = {1'b1, {(DW-1){1'b0}}};
			end else begin
				res.sat   = 1'b0;
				res.value = ~mag[DW-1:0] + DW'(1);
			end
		end else begin
			if (mag > {{(MAGW-DW+1){1'b0}}, {(DW-1){1'b1}}}) begin
				res.sat   = 1'b1;
				res.value = {1'b0, {(DW-1){1'b1}}};
			end else begin
				res.sat   = 1'b0;
				res.value = mag[DW-1:0];
			end
		end
		from_mag = res;
	endfunction

endpackage

>>> rtl/core/gjr_ram.sv
// ----------------------------------------------------------------------------
// gjr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gjr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 136
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/gjr_div.sv
// ----------------------------------------------------------------------------
// gjr_div
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gjr_div
	import gjr_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MAGW-1:0] dividend,
	input  logic [DW-1:0]   divisor,
	output logic            busy,
	output logic            done,
	output logic [MAGW-1:0] quotient
);

	localparam int NW = $clog2(MAGW + 1);

	logic [DW-1:0]   rem_q;
	logic [MAGW-1:0] quo_q;
	logic [DW-1:0]   dsr_q;
	logic [NW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     trial;
	logic [DW:0]     diff;

	assign trial = {rem_q, quo_q[MAGW-1]};
	assign diff  = trial - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(MAGW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The dividend shifts out of the top while quotient bits enter below.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!diff[DW]) begin
				rem_q <= diff[DW-1:0];
				quo_q <= {quo_q[MAGW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[MAGW-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

>>> rtl/core/gauss_jordan_reducer.sv
// ----------------------------------------------------------------------------
// gauss_jordan_reducer
// In-place Gauss-Jordan elimination of a Q16.16 augmented matrix.
// ----------------------------------------------------------------------------
// A write command raises done in the cycle after it is accepted. A read command
// passes through ST_RD_WAIT, which registers done. The matrix RAM has one
// read port and one write port. Each normalized entry goes through the
// bit-serial divider. busy is high while a read or a run is in progress; a
// write never raises it, and done is raised only once busy has fallen. Every
// command returns one word on result, valid only in the cycle that done is
// high. The receiver must take it then, as it is not held.
`timescale 1ns / 1ps

module gauss_jordan_reducer
	import gjr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  gjr_in_t           cmd,
	output logic              done,
	output gjr_out_t          result,
	input  logic              cfg_we,
	input  logic              cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata
);

`include "gauss_jordan_reducer_macros.svh"

	state_t state_q, state_d;

	logic [3:0]    rows_q;
	logic [4:0]    cols_q;
	logic [RW-1:0] m_q, k_q, p_q, i_q;
	logic [CW-1:0] n_q, j_q;
	logic          bwd_q, sat_q, neg_q;
	logic [DW-1:0] piv_q, tmp_q, fac_q;
	logic [2*DW-1:0] prod_q;
	logic [1:0]    status_q;
	logic          done_q;
	logic [DW-1:0] rd_value_q;
	logic          addr_rd_ok_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [DW-1:0] ram_wdata, ram_rdata;
	logic          div_start, div_busy, div_done;
	logic [MAGW-1:0] div_quo;

	logic          accept;
	logic          addr_ok;
	logic [RW-1:0] m_eff;
	logic [CW-1:0] n_eff;
	logic          row_last;
	logic          fwd_more_k;
	logic          bwd_more_i;
	logic          finish_run;
	logic [1:0]    finish_code;
	logic          sub_sat;
	sat_val_t      q_prod, q_quo;
	logic [DW:0]   diff;
	logic [DW-1:0] diff_val;

	assign accept  = start && !busy;
	assign addr_ok = (32'(cmd.row_index) < MAX_ROWS) && (32'(cmd.col_index) <= MAX_COLS);

	always_comb begin
		if (rows_q == '0) begin
			m_eff = RW'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			m_eff = RW'(MAX_ROWS);
		end else begin
			m_eff = RW'(rows_q);
		end
		if (cols_q == '0) begin
			n_eff = CW'(1);
		end else if (32'(cols_q) > MAX_COLS) begin
			n_eff = CW'(MAX_COLS);
		end else begin
			n_eff = CW'(cols_q);
		end
	end

	assign row_last   = (j_q == n_q);
	assign fwd_more_k = (k_q + RW'(1)) < m_q;
	assign bwd_more_i = (i_q + RW'(1)) < k_q;

	// Product and quotient back to Q16.16, then the saturating subtract.
	assign q_prod   = from_mag(neg_q, prod_q[2*DW-1:FRAC]);
	assign q_quo    = from_mag(neg_q, div_quo);
	assign diff     = {ram_rdata[DW-1], ram_rdata} - {q_prod.value[DW-1], q_prod.value};
	assign sub_sat  = diff[DW] != diff[DW-1];
	assign diff_val = sub_sat ? {diff[DW], {(DW-1){~diff[DW]}}} : diff[DW-1:0];

	gjr_ram #(
		.WIDTH(DW),
		.DEPTH(STORE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	gjr_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend({mag_of(ram_rdata), {FRAC{1'b0}}}),
		.divisor (mag_of(piv_q)),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_quo)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && cmd.req_type == REQ_READ) begin
					state_d = ST_RD_WAIT;
				end else if (accept && cmd.req_type == REQ_RUN && n_eff >= CW'(m_eff)) begin
					state_d = ST_PIV_RD;
				end
			end
			ST_RD_WAIT:  state_d = ST_IDLE;
			ST_PIV_RD:   state_d = ST_PIV_CHK;
			ST_PIV_CHK: begin
				if (ram_rdata == '0) begin
					state_d = ((p_q + RW'(1)) < m_q) ? ST_PIV_RD : ST_IDLE;
				end else begin
					state_d = (p_q != k_q) ? ST_SWP_RDA : ST_NRM_RD0;
				end
			end
			ST_SWP_RDA:  state_d = ST_SWP_RDB;
			ST_SWP_RDB:  state_d = ST_SWP_WRA;
			ST_SWP_WRA:  state_d = ST_SWP_WRB;
			ST_SWP_WRB:  state_d = row_last ? ST_NRM_RD0 : ST_SWP_RDA;
			ST_NRM_RD0:  state_d = ST_NRM_PIV;
			ST_NRM_PIV:  state_d = ST_NRM_RD;
			ST_NRM_RD:   state_d = ST_NRM_DIV;
			ST_NRM_DIV:  state_d = ST_NRM_WAIT;
			ST_NRM_WAIT: begin
				if (div_done) begin
					if (!row_last) begin
						state_d = ST_NRM_RD;
					end else if (fwd_more_k) begin
						state_d = ST_ELM_RDF;
					end else begin
						state_d = (m_q == RW'(1)) ? ST_IDLE : ST_ELM_RDF;
					end
				end
			end
			ST_ELM_RDF:  state_d = ST_ELM_FAC;
			ST_ELM_FAC:  state_d = ST_ELM_RDS;
			ST_ELM_RDS:  state_d = ST_ELM_RDD;
			ST_ELM_RDD:  state_d = ST_ELM_WR;
			ST_ELM_WR: begin
				if (!row_last) begin
					state_d = ST_ELM_RDS;
				end else if (!bwd_q) begin
					if ((i_q + RW'(1)) < m_q) begin
						state_d = ST_ELM_RDF;
					end else if (fwd_more_k) begin
						state_d = ST_PIV_RD;
					end else begin
						state_d = ST_ELM_RDF;
					end
				end else begin
					state_d = (bwd_more_i || k_q != RW'(1)) ? ST_ELM_RDF : ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Datapath controls.
	always_comb begin
		ram_we      = 1'b0;
		ram_waddr   = cell_addr(i_q, j_q);
		ram_wdata   = diff_val;
		ram_raddr   = cell_addr(k_q, j_q);
		div_start   = 1'b0;
		finish_run  = 1'b0;
		finish_code = STAT_OK;
		case (state_q)
			ST_IDLE: begin
				ram_raddr = cell_addr(RW'(cmd.row_index), CW'(cmd.col_index));
				ram_waddr = cell_addr(RW'(cmd.row_index), CW'(cmd.col_index));
				ram_wdata = cmd.entry_value;
				ram_we    = accept && cmd.req_type == REQ_WRITE && addr_ok;
				if (accept && cmd.req_type == REQ_RUN && n_eff < CW'(m_eff)) begin
					finish_run  = 1'b1;
					finish_code = STAT_SINGULAR;
				end
			end
			ST_PIV_RD:   ram_raddr = cell_addr(p_q, CW'(k_q));
			ST_PIV_CHK: begin
				if (ram_rdata == '0 && !((p_q + RW'(1)) < m_q)) begin
					finish_run  = 1'b1;
					finish_code = STAT_SINGULAR;
				end
			end
			ST_SWP_RDA:  ram_raddr = cell_addr(k_q, j_q);
			ST_SWP_RDB:  ram_raddr = cell_addr(p_q, j_q);
			ST_SWP_WRA: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(k_q, j_q);
				ram_wdata = ram_rdata;
			end
			ST_SWP_WRB: begin
				ram_we    = 1'b1;
				ram_waddr = cell_addr(p_q, j_q);
				ram_wdata = tmp_q;
			end
			ST_NRM_RD0:  ram_raddr = cell_addr(k_q, CW'(k_q));
			ST_NRM_RD:   ram_raddr = cell_addr(k_q, j_q);
			ST_NRM_DIV:  div_start = 1'b1;
			ST_NRM_WAIT: begin
				ram_waddr = cell_addr(k_q, j_q);
				ram_wdata = q_quo.value;
				ram_we    = div_done;
				if (div_done && row_last && !fwd_more_k && m_q == RW'(1)) begin
					finish_run  = 1'b1;
					finish_code = (sat_q || q_quo.sat) ? STAT_SAT : STAT_OK;
				end
			end
			ST_ELM_RDF:  ram_raddr = cell_addr(i_q, CW'(k_q));
			ST_ELM_RDS:  ram_raddr = cell_addr(k_q, j_q);
			ST_ELM_RDD:  ram_raddr = cell_addr(i_q, j_q);
			ST_ELM_WR: begin
				ram_we = 1'b1;
				if (row_last && bwd_q && !bwd_more_i && k_q == RW'(1)) begin
					finish_run  = 1'b1;
					finish_code = (sat_q || q_prod.sat || sub_sat) ? STAT_SAT : STAT_OK;
				end
			end
			default: begin
			end
		endcase
	end

	// Loop counters and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rows_q   <= 4'd1;
			cols_q   <= 5'd1;
			status_q <= STAT_OK;
			done_q   <= 1'b0;
			bwd_q    <= 1'b0;
			sat_q    <= 1'b0;
			m_q      <= RW'(1);
			n_q      <= CW'(1);
			k_q      <= '0;
			p_q      <= '0;
			i_q      <= '0;
			j_q      <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_addr))
					CFG_ROWS: rows_q <= cfg_wdata[3:0];
					CFG_COLS: cols_q <= cfg_wdata;
					default: begin
					end
				endcase
			end
			if (finish_run) begin
				status_q <= finish_code;
				done_q   <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd.req_type != REQ_READ && cmd.req_type != REQ_RUN) begin
						done_q <= 1'b1;
					end
					if (accept && cmd.req_type == REQ_RUN) begin
						m_q   <= m_eff;
						n_q   <= n_eff;
						k_q   <= '0;
						p_q   <= '0;
						bwd_q <= 1'b0;
						sat_q <= 1'b0;
					end
				end
				ST_RD_WAIT: done_q <= 1'b1;
				ST_PIV_CHK: begin
					j_q <= '0;
					if (ram_rdata == '0) begin
						p_q <= p_q + RW'(1);
					end
				end
				ST_SWP_WRB: j_q <= j_q + CW'(1);
				ST_NRM_PIV: j_q <= '0;
				ST_NRM_WAIT: begin
					if (div_done) begin
						sat_q <= sat_q || q_quo.sat;
						j_q   <= j_q + CW'(1);
						if (row_last) begin
							if (fwd_more_k) begin
								i_q <= k_q + RW'(1);
							end else begin
								bwd_q <= 1'b1;
								k_q   <= m_q - RW'(1);
								i_q   <= '0;
							end
						end
					end
				end
				ST_ELM_FAC: j_q <= '0;
				ST_ELM_WR: begin
					sat_q <= sat_q || q_prod.sat || sub_sat;
					j_q   <= j_q + CW'(1);
					if (row_last) begin
						if (!bwd_q) begin
							if ((i_q + RW'(1)) < m_q) begin
								i_q <= i_q + RW'(1);
							end else if (fwd_more_k) begin
								k_q <= k_q + RW'(1);
								p_q <= k_q + RW'(1);
							end else begin
								bwd_q <= 1'b1;
								k_q   <= m_q - RW'(1);
								i_q   <= '0;
							end
						end else if (bwd_more_i) begin
							i_q <= i_q + RW'(1);
						end else begin
							k_q <= k_q - RW'(1);
							i_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Operand and result words.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:    rd_value_q <= '0;
			ST_RD_WAIT: rd_value_q <= addr_rd_ok_q ? ram_rdata : '0;
			ST_SWP_RDB: tmp_q <= ram_rdata;
			ST_NRM_PIV: piv_q <= ram_rdata;
			ST_NRM_DIV: neg_q <= ram_rdata[DW-1] ^ piv_q[DW-1];
			ST_ELM_FAC: fac_q <= ram_rdata;
			ST_ELM_RDD: begin
				prod_q <= mag_of(ram_rdata) * mag_of(fac_q);
				neg_q  <= ram_rdata[DW-1] ^ fac_q[DW-1];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_rd_ok_q <= addr_ok;
		end
	end

	assign busy              = (state_q != ST_IDLE);
	assign done              = done_q;
	assign result.read_value = rd_value_q;
	assign result.run_status = status_q;

	`GJR_ASSERT_IMP(a_done_idle, done, !busy, "done raised while busy")
	`GJR_ASSERT_IMP(a_waddr_range, ram_we, 32'(ram_waddr) < STORE_DEPTH, "RAM write out of range")
	`GJR_ASSERT_NEVER(a_status_code, status_q == 2'd3, "invalid run status")
	`GJR_ASSERT_IMP(a_div_owner, div_busy, state_q == ST_NRM_WAIT, "divider busy outside normalize")

endmodule
